// ----- hdl/scd_pkg.sv -----
// scd_pkg: shared types, codes and the sine table generator for the stereo chorus
// depends on nothing; imported by the controller, datapath and top level
package scd_pkg;

   localparam int LINE_DEPTH = 16384;
   localparam int SAMPLE_BITS = 24;
   localparam int SINE_TABLE_SIZE = 1024;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 23;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_DELAY = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOD_DEPTH = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_GAIN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_MIX = 3'd5;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LFO,
      OP_MOD,
      OP_ADDR,
      OP_RD1,
      OP_RD2,
      OP_MUL,
      OP_SUM,
      OP_GAIN,
      OP_FIN
   } dp_op_type;

   typedef struct packed {
      logic      accept;
      logic      fire;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic bypass;
   } dp_status_type;

   // quarter-wave polynomial sine, q1.15, for table entry k of a 2^lg entry table
   function automatic logic signed [15:0] sine_entry(input int k, input int lg);
      longint unsigned m;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      longint signed v;
      m = longint'(4 * k);
      quad = m >> lg;
      r = m & ((64'd1 << lg) - 64'd1);
      z = (r << 16) >> lg;
      if (quad[0]) z = 64'd65536 - z;
      z2 = (z * z) >> 16;
      t = (64'd5210 * z2) >> 16;
      t = 64'd42334 - t;
      t = (t * z2) >> 16;
      t = 64'd102944 - t;
      t = ((z * t) >> 16) >> 1;
      if (t > 64'd32767) t = 64'd32767;
      v = quad[1] ? -longint'(t) : longint'(t);
      return v[15:0];
   endfunction

endpackage

// ----- hdl/scd_ifs.sv -----
// scd_ifs: valid/ready channels for input frames and result frames
// no dependencies
interface scd_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic                          block_end;
   modport source (output valid, left_in, right_in, block_end, input ready);
   modport sink (input valid, left_in, right_in, block_end, output ready);
endinterface

interface scd_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          block_end_out;
   modport source (output valid, left_out, right_out, block_end_out, input ready);
   modport sink (input valid, left_out, right_out, block_end_out, output ready);
endinterface

// ----- hdl/stereo_chorus_delay.sv -----
// stereo_chorus_delay: top level joining the sequencer and the chorus datapath
// depends on scd_pkg, scd_ifs, scd_ctrl and scd_datapath
//
// Stereo chorus with one lfo-modulated, linearly interpolated delay line per channel
// (sine on the left, cosine on the right) with feedback and a wet/dry mix. The sequencer
// steps each accepted frame through table lookup, delay multiply, address, two reads of
// each line, interpolation, gain products and the final write; the final write waits
// while the previous result is not yet taken from the output. The input becomes ready
// again at the clock edge that loads the result register, so only one word is in flight
// at a time. A bypassed word goes from acceptance straight to the final step. A new word
// is taken while the previous result waits on the output. Entries of the lines not yet
// written read as zero by tracking the write position since reset, so no clearing pass
// is needed.
module stereo_chorus_delay
   import scd_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input logic                        clock,
   input logic                        reset,
   scd_req_if.sink                    req_if,
   scd_rsp_if.source                  rsp_if,
   input logic                        csr_we,
   input logic [CSR_INDEX_BITS-1:0]   csr_index,
   input logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scd_datapath #(
      .PHASE_BITS (PHASE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .left_in       (req_if.left_in),
      .right_in      (req_if.right_in),
      .block_end     (req_if.block_end),
      .left_out      (rsp_if.left_out),
      .right_out     (rsp_if.right_out),
      .block_end_out (rsp_if.block_end_out)
   );

   a_fin_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result loaded over a waiting word");

   a_fire_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> rsp_if.valid)
      else $error("finished word not presented");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (cmd.op == OP_IDLE))
      else $error("input taken while a word is in flight");

endmodule

// ----- hdl/scd_ctrl.sv -----
// scd_ctrl: sequencer for one frame through the chorus datapath and the output handshake
// depends on scd_pkg
module scd_ctrl
   import scd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LFO,
      ST_MOD,
      ST_ADDR,
      ST_RD1,
      ST_RD2,
      ST_MUL,
      ST_SUM,
      ST_GAIN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   dp_op_type op_ff, op_in;
   logic      ready_ff, ready_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;
   logic      slot_free;
   logic      fire;

   assign accept = req_valid && ready_ff;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign fire = (state_ff == ST_FIN) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = status.bypass ? ST_FIN : ST_LFO;
         ST_LFO:  state_in = ST_MOD;
         ST_MOD:  state_in = ST_ADDR;
         ST_ADDR: state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_GAIN;
         ST_GAIN: state_in = ST_FIN;
         ST_FIN:  if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      unique case (state_in)
         ST_IDLE: op_in = OP_IDLE;
         ST_LFO:  op_in = OP_LFO;
         ST_MOD:  op_in = OP_MOD;
         ST_ADDR: op_in = OP_ADDR;
         ST_RD1:  op_in = OP_RD1;
         ST_RD2:  op_in = OP_RD2;
         ST_MUL:  op_in = OP_MUL;
         ST_SUM:  op_in = OP_SUM;
         ST_GAIN: op_in = OP_GAIN;
         ST_FIN:  op_in = OP_FIN;
         default: op_in = OP_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
      out_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_IDLE;
         ready_ff <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         ready_ff <= ready_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = out_valid_ff;
   assign cmd.accept = accept;
   assign cmd.fire = fire;
   assign cmd.op = op_ff;

endmodule

// ----- hdl/scd_datapath.sv -----
// scd_datapath: control registers, lfo, delay line memories, interpolation and mixing
// depends on scd_pkg; driven by scd_ctrl commands
module scd_datapath
   import scd_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata,
   input  dp_cmd_type                      cmd,
   output dp_status_type                   status,
   input  logic signed [SAMPLE_BITS-1:0]   left_in,
   input  logic signed [SAMPLE_BITS-1:0]   right_in,
   input  logic                            block_end,
   output logic signed [SAMPLE_BITS-1:0]   left_out,
   output logic signed [SAMPLE_BITS-1:0]   right_out,
   output logic                            block_end_out
);

   localparam int SB = SAMPLE_BITS;
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int RW = AW + 8;
   localparam int LG = $clog2(SINE_TABLE_SIZE);

   logic signed [15:0] sine_rom [SINE_TABLE_SIZE];
   for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_rom
      localparam logic signed [15:0] ENTRY = sine_entry(k, LG);
      assign sine_rom[k] = ENTRY;
   end

   logic                  enable_ff;
   logic [22:0]           step_ff;
   logic [20:0]           base_ff;
   logic [19:0]           depth_ff;
   logic [14:0]           fbg_ff;
   logic [15:0]           wet_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [AW-1:0]         wp_ff;
   logic                  wrapped_ff;
   logic                  byp_ff;
   logic                  be_ff;

   logic signed [SB-1:0]  x_ff [2];
   logic signed [15:0]    lfo_ff [2];
   logic signed [21:0]    mod_ff [2];
   logic [AW-1:0]         i1_ff [2];
   logic [7:0]            f_ff [2];
   logic signed [SB-1:0]  rd_ff [2];
   logic signed [SB-1:0]  a_ff [2];
   logic                  v1_ff [2];
   logic                  v2_ff [2];
   logic signed [SB+9:0]  pa_ff [2];
   logic signed [SB+9:0]  pb_ff [2];
   logic signed [SB-1:0]  dly_ff [2];
   logic signed [SB+15:0] pfb_ff [2];
   logic signed [SB+16:0] pwet_ff [2];
   logic signed [SB+16:0] pdry_ff [2];
   logic signed [SB-1:0]  y_ff [2];

   logic [LG-1:0]         idx [2];
   logic [15:0]           wet_c;
   logic signed [16:0]    wet_s;
   logic signed [16:0]    dry_s;

   function automatic logic signed [SB-1:0] sat_wide(input logic signed [SB+2:0] v);
      logic signed [SB-1:0] r;
      if (v[SB+2:SB-1] == '0 || v[SB+2:SB-1] == '1) r = v[SB-1:0];
      else if (v[SB+2]) r = {1'b1, {(SB-1){1'b0}}};
      else r = {1'b0, {(SB-1){1'b1}}};
      return r;
   endfunction

   assign idx[0] = phase_ff[PHASE_BITS-1 -: LG];
   assign idx[1] = idx[0] + LG'(SINE_TABLE_SIZE / 4);
   assign wet_c = (wet_ff > 16'd32768) ? 16'd32768 : wet_ff;
   assign wet_s = $signed({1'b0, wet_c});
   assign dry_s = 17'sd32768 - wet_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         step_ff <= 23'd202573;
         base_ff <= 21'd169344;
         depth_ff <= 20'd28224;
         fbg_ff <= 15'd6226;
         wet_ff <= 16'd16384;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:        enable_ff <= csr_wdata[0];
            CSR_PHASE_STEP:    step_ff <= csr_wdata[22:0];
            CSR_BASE_DELAY:    base_ff <= csr_wdata[20:0];
            CSR_MOD_DEPTH:     depth_ff <= csr_wdata[19:0];
            CSR_FEEDBACK_GAIN: fbg_ff <= csr_wdata[14:0];
            CSR_WET_MIX:       wet_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         wp_ff <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         if (cmd.accept && enable_ff) phase_ff <= phase_ff + PHASE_BITS'(step_ff);
         if (cmd.fire && !byp_ff) begin
            wp_ff <= wp_ff + AW'(1);
            if (wp_ff == '1) wrapped_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff[0] <= left_in;
         x_ff[1] <= right_in;
         be_ff <= block_end;
         byp_ff <= !enable_ff;
      end
   end

   for (genvar c = 0; c < 2; c++) begin : g_ch
      logic signed [SB-1:0] line_mem [LINE_DEPTH];
      logic signed [36:0]   mprod;
      logic signed [23:0]   dsum;
      logic [22:0]          dpos;
      logic [RW-1:0]        rp;
      logic [AW-1:0]        rd_addr;
      logic                 rd_ok;
      logic signed [SB-1:0] b_val;
      logic signed [SB+10:0] psum;
      logic signed [SB+1:0] lsum;
      logic signed [SB+17:0] ysum;
      logic signed [SB-1:0] wr_val;

      assign mprod = $signed({1'b0, depth_ff}) * lfo_ff[c];
      assign dsum = $signed({3'b000, base_ff}) + {{2{mod_ff[c][21]}}, mod_ff[c]};
      assign dpos = dsum[23] ? 23'd0 : dsum[22:0];
      assign rp = {wp_ff, 8'h00} - RW'(dpos);
      assign rd_addr = (cmd.op == OP_RD2) ? i1_ff[c] + AW'(1) : i1_ff[c];
      assign rd_ok = wrapped_ff || (rd_addr < wp_ff);
      assign b_val = v2_ff[c] ? rd_ff[c] : '0;
      assign psum = {pa_ff[c][SB+9], pa_ff[c]} + {pb_ff[c][SB+9], pb_ff[c]};
      assign lsum = {{2{x_ff[c][SB-1]}}, x_ff[c]} + {pfb_ff[c][SB+15], pfb_ff[c][SB+15:15]};
      assign ysum = {pwet_ff[c][SB+16], pwet_ff[c]} + {pdry_ff[c][SB+16], pdry_ff[c]};
      assign wr_val = sat_wide({lsum[SB+1], lsum});

      always_ff @(posedge clock) begin
         rd_ff[c] <= line_mem[rd_addr];
         if (cmd.fire && !byp_ff) line_mem[wp_ff] <= wr_val;
      end

      always_ff @(posedge clock) begin
         case (cmd.op)
            OP_LFO:  lfo_ff[c] <= sine_rom[idx[c]];
            OP_MOD:  mod_ff[c] <= mprod[36:15];
            OP_ADDR: begin
               i1_ff[c] <= rp[RW-1:8];
               f_ff[c] <= rp[7:0];
            end
            OP_RD1:  v1_ff[c] <= rd_ok;
            OP_RD2:  begin
               v2_ff[c] <= rd_ok;
               a_ff[c] <= v1_ff[c] ? rd_ff[c] : '0;
            end
            OP_MUL:  begin
               pa_ff[c] <= a_ff[c] * $signed({1'b0, 9'd256 - {1'b0, f_ff[c]}});
               pb_ff[c] <= b_val * $signed({2'b00, f_ff[c]});
            end
            OP_SUM:  dly_ff[c] <= psum[SB+7:8];
            OP_GAIN: begin
               pfb_ff[c] <= dly_ff[c] * $signed({1'b0, fbg_ff});
               pwet_ff[c] <= dly_ff[c] * wet_s;
               pdry_ff[c] <= x_ff[c] * dry_s;
            end
            default: ;
         endcase
         if (cmd.fire) y_ff[c] <= byp_ff ? x_ff[c] : sat_wide(ysum[SB+17:15]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) block_end_out <= be_ff;
   end

   assign left_out = y_ff[0];
   assign right_out = y_ff[1];
   assign status.bypass = !enable_ff;

endmodule

// ----- tb/stereo_chorus_delay_test.sv -----
// stereo_chorus_delay_test: self-checking bench for the stereo chorus, with a directed table
// followed by random-frame phases, checked against table values or a bit-exact predictor
// depends on scd_pkg, scd_ifs and the stereo_chorus_delay rtl
`timescale 1ns / 100ps

module stereo_chorus_delay_test;
   import scd_pkg::*;

   localparam int LIMIT = 400000;
   localparam int SETTLE = 24;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd6;

   typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_type;

   typedef struct packed {
      logic signed [23:0] l;
      logic signed [23:0] r;
      logic               be;
   } frame_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [CSR_DATA_BITS-1:0]  data;
      frame_type                 stim;
      logic                      has_exp;
      frame_type                 exp;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   scd_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req ();
   scd_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp ();

   stereo_chorus_delay DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req),
      .rsp_if(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state
   logic signed [15:0] sine_tab [1024];
   logic signed [23:0] left_line [16384];
   logic signed [23:0] right_line [16384];
   logic        chorus_on = 1'b1;
   logic [22:0] step_reg = 23'd202573;
   logic [20:0] base_reg = 21'd169344;
   logic [19:0] depth_reg = 20'd28224;
   logic [14:0] fb_reg = 15'd6226;
   logic [15:0] wet_reg = 16'd16384;
   logic [31:0] osc_phase = '0;
   logic [13:0] wr_pos = '0;

   frame_type expected_q [$];
   frame_type cur_exp;
   logic      cur_has_exp = 1'b0;
   frame_type pred_frame;
   frame_type got_frame;
   frame_type want_frame;
   int errors = 0;
   int cycles = 0;
   bit calm = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [23:0] sat24(input longint v);
      if (v > 64'sd8388607) return 24'sd8388607;
      if (v < -64'sd8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   function automatic longint line_tap(input bit right_side, input longint lfo);
      longint m;
      longint d;
      logic [21:0] rp;
      logic [13:0] i1;
      logic [13:0] i2;
      longint f;
      longint a;
      longint b;
      m = (longint'(depth_reg) * lfo) >>> 15;
      d = longint'(base_reg) + m;
      if (d < 0) d = 0;
      rp = {wr_pos, 8'h00} - d[21:0];
      i1 = rp[21:8];
      i2 = i1 + 14'd1;
      f = longint'(rp[7:0]);
      a = longint'(right_side ? right_line[i1] : left_line[i1]);
      b = longint'(right_side ? right_line[i2] : left_line[i2]);
      return (a * (256 - f) + b * f) >>> 8;
   endfunction

   task automatic chorus_predict(input frame_type x, output frame_type y);
      longint dl;
      longint dr;
      longint xl;
      longint xr;
      longint wet;
      logic [31:0] cos_phase;
      y.be = x.be;
      if (!chorus_on) begin
         y.l = x.l;
         y.r = x.r;
         return;
      end
      xl = longint'(x.l);
      xr = longint'(x.r);
      osc_phase = osc_phase + 32'(step_reg);
      cos_phase = osc_phase + 32'h4000_0000;
      dl = line_tap(1'b0, longint'(sine_tab[osc_phase[31:22]]));
      dr = line_tap(1'b1, longint'(sine_tab[cos_phase[31:22]]));
      left_line[wr_pos] = sat24(xl + ((dl * longint'(fb_reg)) >>> 15));
      right_line[wr_pos] = sat24(xr + ((dr * longint'(fb_reg)) >>> 15));
      wr_pos = wr_pos + 14'd1;
      wet = (wet_reg > 16'd32768) ? 32768 : longint'(wet_reg);
      y.l = sat24((dl * wet + xl * (32768 - wet)) >>> 15);
      y.r = sat24((dr * wet + xr * (32768 - wet)) >>> 15);
   endtask

   task automatic chorus_config(input logic [CSR_INDEX_BITS-1:0] idx,
                                input logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_ENABLE: chorus_on = val[0];
         CSR_PHASE_STEP: step_reg = val[22:0];
         CSR_BASE_DELAY: base_reg = val[20:0];
         CSR_MOD_DEPTH: depth_reg = val[19:0];
         CSR_FEEDBACK_GAIN: fb_reg = val[14:0];
         CSR_WET_MIX: wet_reg = val[15:0];
         default: ;
      endcase
   endtask

   // quarter-wave polynomial sine table, q1.15
   initial begin
      longint m, quad, z, z2, t;
      for (int k = 0; k < 1024; k++) begin
         m = 4 * k;
         quad = m >> 10;
         z = ((m & 1023) << 16) >> 10;
         if (quad[0]) z = 65536 - z;
         z2 = (z * z) >> 16;
         t = (5210 * z2) >> 16;
         t = 42334 - t;
         t = (t * z2) >> 16;
         t = 102944 - t;
         t = ((z * t) >> 16) >> 1;
         if (t > 32767) t = 32767;
         sine_tab[k] = quad[1] ? -t[15:0] : t[15:0];
      end
      for (int k = 0; k < 16384; k++) begin
         left_line[k] = '0;
         right_line[k] = '0;
      end
   end

   function automatic int gap_len();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [23:0] rand_sample();
      int p;
      p = $urandom_range(0, 19);
      if (p == 0) return 24'sd8388607;
      if (p == 1) return -24'sd8388608;
      if (p == 2) return 24'($urandom_range(0, 15) - 8);
      return 24'($urandom);
   endfunction

   // checking
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL stereo_chorus_delay");
         $finish;
      end
      if (!reset) begin
         if (req.valid && req.ready) begin
            chorus_predict('{req.left_in, req.right_in, req.block_end}, pred_frame);
            expected_q.push_back(cur_has_exp ? cur_exp : pred_frame);
         end
         if (rsp.valid && rsp.ready) begin
            got_frame = '{rsp.left_out, rsp.right_out, rsp.block_end_out};
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word l=%0d r=%0d be=%0b",
                                          got_frame.l, got_frame.r, got_frame.be);
            end else begin
               want_frame = expected_q.pop_front();
               if (got_frame !== want_frame) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp l=%0d r=%0d be=%0b got l=%0d r=%0d be=%0b",
                              want_frame.l, want_frame.r, want_frame.be,
                              got_frame.l, got_frame.r, got_frame.be);
               end
            end
         end
      end
   end

   // result side stalls
   initial begin
      int g;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // called on a falling edge, returns on a falling edge
   task automatic send_frame(input frame_type x, input logic has, input frame_type e);
      int g;
      req.valid <= 1'b1;
      req.left_in <= x.l;
      req.right_in <= x.r;
      req.block_end <= x.be;
      cur_has_exp = has;
      cur_exp = e;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      chorus_config(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   row_type dir_tab [] = '{
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd8388607, -24'sd8388608, 1'b1}, 1'b1,
        '{24'sd4194303, -24'sd4194304, 1'b1}},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{-24'sd8388608, 24'sd8388607, 1'b0}, 1'b1,
        '{-24'sd4194304, 24'sd4194303, 1'b0}},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd0, -24'sd1, 1'b0}, 1'b1,
        '{24'sd0, -24'sd1, 1'b0}},
      '{ROW_CFG, CSR_ENABLE, 23'd0, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd8388607, -24'sd8388608, 1'b1}, 1'b1,
        '{24'sd8388607, -24'sd8388608, 1'b1}},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{-24'sd8388608, 24'sd8388607, 1'b0}, 1'b1,
        '{-24'sd8388608, 24'sd8388607, 1'b0}},
      '{ROW_CFG, CSR_ENABLE, 23'd1, '0, 1'b0, '0},
      // negative delay clamped: no base, full depth, fastest lfo
      '{ROW_CFG, CSR_BASE_DELAY, 23'd0, '0, 1'b0, '0},
      '{ROW_CFG, CSR_MOD_DEPTH, 23'd1048575, '0, 1'b0, '0},
      '{ROW_CFG, CSR_PHASE_STEP, 23'd8388607, '0, 1'b0, '0},
      '{ROW_CFG, CSR_FEEDBACK_GAIN, 23'd32767, '0, 1'b0, '0},
      '{ROW_CFG, CSR_WET_MIX, 23'd65535, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd8388607, 24'sd8388607, 1'b0}, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd8388607, -24'sd8388608, 1'b1}, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{-24'sd8388608, -24'sd8388608, 1'b0}, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd1234567, -24'sd7654321, 1'b0}, 1'b0, '0},
      // longest base delay, no depth: the read address wraps below entry zero
      '{ROW_CFG, CSR_BASE_DELAY, 23'd2097151, '0, 1'b0, '0},
      '{ROW_CFG, CSR_MOD_DEPTH, 23'd0, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd8388607, 24'sd100, 1'b1}, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{-24'sd3, 24'sd8388607, 1'b0}, 1'b0, '0},
      // half-sample delay taps the current write entry
      '{ROW_CFG, CSR_BASE_DELAY, 23'd128, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd4000000, -24'sd4000000, 1'b0}, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{-24'sd8388608, 24'sd8388607, 1'b1}, 1'b0, '0},
      '{ROW_CFG, CSR_SPARE, 23'd123, '0, 1'b0, '0},
      '{ROW_CFG, CSR_WET_MIX, 23'd0, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd7777777, -24'sd5, 1'b0}, 1'b0, '0},
      '{ROW_CFG, CSR_WET_MIX, 23'd32768, '0, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{24'sd1, -24'sd8388608, 1'b1}, 1'b0, '0},
      '{ROW_FRAME, CSR_ENABLE, 23'd0, '{-24'sd1, 24'sd2, 1'b0}, 1'b0, '0}
   };

   initial begin
      frame_type x;
      req.valid = 1'b0;
      req.left_in = '0;
      req.right_in = '0;
      req.block_end = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ENABLE;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CFG) begin
            wait_idle();
            write_reg(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            send_frame(dir_tab[i].stim, dir_tab[i].has_exp, dir_tab[i].exp);
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         calm = (ph == 3);
         case (ph)
            0: begin
               write_reg(CSR_ENABLE, 23'd1);
               write_reg(CSR_PHASE_STEP, 23'd8388607);
               write_reg(CSR_BASE_DELAY, 23'd2096896);
               write_reg(CSR_MOD_DEPTH, 23'd1048320);
               write_reg(CSR_FEEDBACK_GAIN, 23'd31130);
               write_reg(CSR_WET_MIX, 23'd32768);
            end
            1: begin
               write_reg(CSR_ENABLE, 23'd1);
               write_reg(CSR_PHASE_STEP, 23'd0);
               write_reg(CSR_BASE_DELAY, 23'd0);
               write_reg(CSR_MOD_DEPTH, 23'd0);
               write_reg(CSR_FEEDBACK_GAIN, 23'd0);
               write_reg(CSR_WET_MIX, 23'd0);
            end
            default: begin
               write_reg(CSR_ENABLE, (ph == 2) ? 23'd0 : 23'd1);
               write_reg(CSR_PHASE_STEP, ($urandom_range(0, 3) == 0) ?
                         23'($urandom_range(0, 8388607)) :
                         23'($urandom_range(0, 400000)));
               write_reg(CSR_BASE_DELAY, 23'($urandom_range(0, 64 * 256)));
               write_reg(CSR_MOD_DEPTH, 23'($urandom_range(0, 48 * 256)));
               write_reg(CSR_FEEDBACK_GAIN, 23'($urandom_range(0, 31130)));
               write_reg(CSR_WET_MIX, 23'($urandom_range(0, 32768)));
            end
         endcase
         for (int n = 0; n < 100; n++) begin
            if (ph == 4 && n == 50) begin
               req.valid <= 1'b0;
               while (expected_q.size() != 0) @(negedge clock);
               @(negedge clock);
            end
            x.l = rand_sample();
            x.r = rand_sample();
            x.be = ($urandom_range(0, 7) == 0);
            send_frame(x, 1'b0, '0);
         end
      end

      wait_idle();
      if (errors == 0 && expected_q.size() == 0) begin
         $display("PASS stereo_chorus_delay");
      end else begin
         $display("FAIL stereo_chorus_delay");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/scd_pkg.sv
hdl/scd_ifs.sv
hdl/scd_ctrl.sv
hdl/scd_datapath.sv
hdl/stereo_chorus_delay.sv
tb/stereo_chorus_delay_test.sv
